### rtl/core/vpst_pkg.sv
// Shared types, constants and the taper table for the padded volume reader.
package vpst_pkg;

    // Default sizing of the original volume store and of the padded volume.
    localparam int MAX_OLD_X_DEF    = 64;
    localparam int MAX_OLD_Y_DEF    = 64;
    localparam int MAX_OLD_Z_DEF    = 16;
    localparam int MAX_NEW_SIZE_DEF = 255;

    // Reset values of the size registers.
    localparam logic [6:0] OLD_X_RST = 7'd64;
    localparam logic [6:0] OLD_Y_RST = 7'd64;
    localparam logic [5:0] OLD_Z_RST = 6'd32;
    localparam logic [7:0] NEW_X_RST = 8'd128;
    localparam logic [7:0] NEW_Y_RST = 8'd128;
    localparam logic [7:0] NEW_Z_RST = 8'd64;

    // Slice offset from which the edge copy and taper bands appear.
    localparam logic [7:0] BAND_MIN_OFFSET = 8'd9;
    localparam logic [8:0] EDGE_LAST_DIST  = 9'd3;
    localparam logic [8:0] BAND_LAST_DIST  = 9'd9;
    localparam logic [8:0] TAPER_BASE      = 9'd10;

    // Rounding constant for a product with a Q0.15 factor.
    localparam logic [30:0] Q15_HALF = 31'd16384;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        SRC_ZERO  = 2'd0,
        SRC_COPY  = 2'd1,
        SRC_EDGE  = 2'd2,
        SRC_TAPER = 2'd3
    } t_src_kind;

    typedef enum logic [2:0] {
        CFG_OLD_X = 3'd0,
        CFG_OLD_Y = 3'd1,
        CFG_OLD_Z = 3'd2,
        CFG_NEW_X = 3'd3,
        CFG_NEW_Y = 3'd4,
        CFG_NEW_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_cmd               command;
        logic        [7:0]  coord_x;
        logic        [7:0]  coord_y;
        logic        [7:0]  coord_z;
        logic signed [15:0] voxel_in;
    } t_req;

    typedef struct packed {
        logic signed [15:0] voxel_out;
        t_src_kind          source_kind;
    } t_rsp;

    typedef struct packed {
        logic [6:0] old_size_x;
        logic [6:0] old_size_y;
        logic [5:0] old_size_z;
        logic [7:0] new_size_x;
        logic [7:0] new_size_y;
        logic [7:0] new_size_z;
    } t_cfg;

    // Decision for one request, handed from the address stage onward.
    typedef struct packed {
        logic      we;
        logic      re;
        t_src_kind kind;
        logic [2:0] taper_m;
    } t_map_info;

    // Factor m/7 in Q0.15, rounded.
    function automatic logic [14:0] taper_coef(input logic [2:0] m);
        logic [14:0] c;
        case (m)
            3'd1:    c = 15'd4681;
            3'd2:    c = 15'd9362;
            3'd3:    c = 15'd14043;
            3'd4:    c = 15'd18725;
            3'd5:    c = 15'd23406;
            3'd6:    c = 15'd28087;
            default: c = 15'd0;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/vpst_ram.sv
// Generic single-port RAM with a registered read.
module vpst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/vpst_map.sv
// Address stage: maps a request onto a store address and a source decision.
module vpst_map #(
    parameter int MAX_OLD_X    = vpst_pkg::MAX_OLD_X_DEF,
    parameter int MAX_OLD_Y    = vpst_pkg::MAX_OLD_Y_DEF,
    parameter int MAX_OLD_Z    = vpst_pkg::MAX_OLD_Z_DEF,
    parameter int MAX_NEW_SIZE = vpst_pkg::MAX_NEW_SIZE_DEF,
    parameter int AW           = 16
) (
    input  logic                i_accept,
    input  vpst_pkg::t_req      i_req,
    input  vpst_pkg::t_cfg      i_cfg,
    output vpst_pkg::t_map_info o_info,
    output logic [AW-1:0]       o_addr
);
    import vpst_pkg::*;

    logic [6:0] ox, oy;
    logic [5:0] oz;
    logic [7:0] nx, ny, nz;
    logic [7:0] ix, iy, kz;
    logic [7:0] cx, cy, cz;
    logic [7:0] px, py, pz;
    logic       in_range, in_z, below, band, xy_ok, load_ok, take;
    logic [8:0] slice_dist;
    logic [5:0] sz;
    logic [7:0] ax, ay;
    logic [5:0] az;
    logic [8:0] m_full;

    always_comb begin
        // Clamp the programmed sizes to what the store and output can hold.
        ox = (32'(i_cfg.old_size_x) > MAX_OLD_X) ? 7'(MAX_OLD_X) : i_cfg.old_size_x;
        oy = (32'(i_cfg.old_size_y) > MAX_OLD_Y) ? 7'(MAX_OLD_Y) : i_cfg.old_size_y;
        oz = (32'(i_cfg.old_size_z) > MAX_OLD_Z) ? 6'(MAX_OLD_Z) : i_cfg.old_size_z;
        nx = (32'(i_cfg.new_size_x) > MAX_NEW_SIZE) ? 8'(MAX_NEW_SIZE) : i_cfg.new_size_x;
        ny = (32'(i_cfg.new_size_y) > MAX_NEW_SIZE) ? 8'(MAX_NEW_SIZE) : i_cfg.new_size_y;
        nz = (32'(i_cfg.new_size_z) > MAX_NEW_SIZE) ? 8'(MAX_NEW_SIZE) : i_cfg.new_size_z;

        ix = (nx >= {1'b0, ox}) ? ((nx - {1'b0, ox}) >> 1) : 8'd0;
        iy = (ny >= {1'b0, oy}) ? ((ny - {1'b0, oy}) >> 1) : 8'd0;
        kz = (nz >= {2'b0, oz}) ? ((nz - {2'b0, oz}) >> 1) : 8'd0;

        cx = i_req.coord_x;
        cy = i_req.coord_y;
        cz = i_req.coord_z;

        in_range = (cx < nx) && (cy < ny) && (cz < nz) && (oz != 6'd0);
        pz       = cz - kz;
        in_z     = (cz >= kz) && (pz < {2'b0, oz});
        below    = cz < kz;

        // Distance from the nearest original end slice, counted from one.
        if (below) begin
            slice_dist = {1'b0, kz} - {1'b0, cz};
        end else begin
            slice_dist = {1'b0, cz} - {1'b0, kz} - {3'b0, oz} + 9'd1;
        end
        band = !in_z && (kz >= BAND_MIN_OFFSET) && (slice_dist >= 9'd1)
            && (slice_dist <= BAND_LAST_DIST);

        if (in_z) begin
            sz = pz[5:0];
        end else if (below) begin
            sz = 6'd0;
        end else begin
            sz = oz - 6'd1;
        end

        px    = cx - ix;
        py    = cy - iy;
        xy_ok = (cx >= ix) && (cy >= iy) && (px < {1'b0, ox}) && (py < {1'b0, oy});
        take  = in_range && xy_ok && (in_z || band);

        load_ok = (cx < {1'b0, ox}) && (cy < {1'b0, oy}) && (cz < {2'b0, oz});

        if (i_req.command == CMD_LOAD) begin
            ax = cx;
            ay = cy;
            az = cz[5:0];
        end else begin
            ax = px;
            ay = py;
            az = sz;
        end
        o_addr = AW'((int'(az) * MAX_OLD_Y + int'(ay)) * MAX_OLD_X + int'(ax));

        m_full = TAPER_BASE - slice_dist;

        o_info.we      = i_accept && (i_req.command == CMD_LOAD) && load_ok;
        o_info.re      = i_accept && (i_req.command == CMD_READ);
        o_info.taper_m = m_full[2:0];
        if (!take) begin
            o_info.kind = SRC_ZERO;
        end else if (in_z) begin
            o_info.kind = SRC_COPY;
        end else if (slice_dist <= EDGE_LAST_DIST) begin
            o_info.kind = SRC_EDGE;
        end else begin
            o_info.kind = SRC_TAPER;
        end
    end

endmodule

### rtl/core/vpst_scale.sv
// Result stage: waits for store data, applies the taper and drives the result.
module vpst_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vpst_pkg::t_map_info i_info,
    input  logic signed [15:0]  i_rdata,
    output logic                o_strobe,
    output vpst_pkg::t_rsp      o_result
);
    import vpst_pkg::*;

    logic       r_s1_valid;
    t_src_kind  r_s1_kind;
    logic [2:0] r_s1_m;
    logic       r_strobe;
    t_rsp       r_result;
    t_rsp       n_result;

    logic        neg;
    logic [15:0] mag;
    logic [30:0] prod;
    logic [30:0] rsum;
    logic [15:0] rmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s1_valid <= i_info.re;
            r_strobe   <= r_s1_valid;
        end
        r_s1_kind <= i_info.kind;
        r_s1_m    <= i_info.taper_m;
        r_result  <= n_result;
    end

    always_comb begin
        neg  = i_rdata[15];
        mag  = neg ? 16'(-i_rdata) : 16'(i_rdata);
        prod = 31'(mag) * 31'(taper_coef(r_s1_m));
        rsum = prod + Q15_HALF;
        rmag = rsum[30:15];

        n_result.source_kind = r_s1_kind;
        case (r_s1_kind)
            SRC_COPY:  n_result.voxel_out = i_rdata;
            SRC_EDGE:  n_result.voxel_out = i_rdata;
            SRC_TAPER: n_result.voxel_out = neg ? -$signed(rmag) : $signed(rmag);
            default:   n_result.voxel_out = 16'sd0;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### rtl/core/volume_pad_with_slice_taper_unit.sv
// Top level of the padded volume reader with edge slice taper.
// A read request passes the store read register and then the result register, and
// o_strobe marks its result as it leaves the result register.
// Throughput: one request per cycle, set by the single store port; o_busy stays low.
// Reset clears the size registers to their defaults and empties the result pipeline.
// The volume store is not cleared; each voxel holds garbage until it is loaded.
module volume_pad_with_slice_taper_unit #(
    parameter int MAX_OLD_X    = vpst_pkg::MAX_OLD_X_DEF,
    parameter int MAX_OLD_Y    = vpst_pkg::MAX_OLD_Y_DEF,
    parameter int MAX_OLD_Z    = vpst_pkg::MAX_OLD_Z_DEF,
    parameter int MAX_NEW_SIZE = vpst_pkg::MAX_NEW_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  vpst_pkg::t_req i_req,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_wdata,
    output logic           o_strobe,
    output vpst_pkg::t_rsp o_result
);
    import vpst_pkg::*;

    // The store holds the largest original volume, addressed z-major then y then x.
    localparam int STORE_DEPTH = MAX_OLD_X * MAX_OLD_Y * MAX_OLD_Z;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    t_map_info          map_info;
    logic [AW-1:0]      store_addr;
    logic [15:0]        store_rdata;
    logic               accept;

    // Every request is taken at once: each request makes at most one store access
    // and no access ever waits on another.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // Size registers. A write to an index past the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.old_size_x <= OLD_X_RST;
            r_cfg.old_size_y <= OLD_Y_RST;
            r_cfg.old_size_z <= OLD_Z_RST;
            r_cfg.new_size_x <= NEW_X_RST;
            r_cfg.new_size_y <= NEW_Y_RST;
            r_cfg.new_size_z <= NEW_Z_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OLD_X: n_cfg.old_size_x = i_cfg_wdata[6:0];
                CFG_OLD_Y: n_cfg.old_size_y = i_cfg_wdata[6:0];
                CFG_OLD_Z: n_cfg.old_size_z = i_cfg_wdata[5:0];
                CFG_NEW_X: n_cfg.new_size_x = i_cfg_wdata;
                CFG_NEW_Y: n_cfg.new_size_y = i_cfg_wdata;
                CFG_NEW_Z: n_cfg.new_size_z = i_cfg_wdata;
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    // The address stage works on the request in its accept cycle, so the store
    // sees the address at the same edge that takes the request.
    vpst_map #(
        .MAX_OLD_X    (MAX_OLD_X),
        .MAX_OLD_Y    (MAX_OLD_Y),
        .MAX_OLD_Z    (MAX_OLD_Z),
        .MAX_NEW_SIZE (MAX_NEW_SIZE),
        .AW           (AW)
    ) u_map (
        .i_accept (accept),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .o_info   (map_info),
        .o_addr   (store_addr)
    );

    vpst_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (map_info.we),
        .i_re    (map_info.re),
        .i_addr  (store_addr),
        .i_wdata (i_req.voxel_in),
        .o_rdata (store_rdata)
    );

    // The result stage picks up the store data in the cycle after the read, applies the
    // taper where needed and registers the outgoing result.
    vpst_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_info   (map_info),
        .i_rdata  (store_rdata),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    logic rd_acc;
    assign rd_acc = i_rst_n && accept && (i_req.command == CMD_READ);

    // Every read request is followed by a result once it has passed the store and result registers.
    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |=> ##1 o_strobe)
        else $error("read request without result");

    // No result appears without a read request that has passed the store and result registers.
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(rd_acc, 2))
        else $error("result without read request");

    // A padding result always carries a zero voxel.
    a_pad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.source_kind == SRC_ZERO)) |-> (o_result.voxel_out == 16'sd0))
        else $error("padding result with nonzero voxel");

endmodule
